/* design/ssp_pkg.sv */
// shared types and constants for the sensor poll responder
// no dependencies
package ssp_pkg;

  localparam logic [7:0] FRAME_START = 8'h7E;
  localparam logic [7:0] ESCAPE_MARK = 8'h7D;
  localparam logic [7:0] ESCAPE_FLIP = 8'h20;
  localparam logic [7:0] DATA_HEADER = 8'h10;
  localparam logic [2:0] LAST_INDEX  = 3'd7;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SEND
  } tx_state_t;

  typedef struct packed {
    logic        start;
    logic [15:0] value_id;
    logic [31:0] value_word;
  } frame_req_t;

  typedef struct packed {
    logic busy;
  } frame_stat_t;

endpackage

/* design/sport_sensor_poll_responder.sv */
// top level of the polled bus sensor responder: item intake, poll detection,
// address register; depends on ssp_pkg and ssp_frame_tx
//
// A load item or a bus byte that is not a poll for this sensor starts no frame and
// raises no stall. A poll that finds a reply pending starts a frame of 8 to 15 bytes,
// which the serializer sends one byte per cycle, unless out_stall holds it, from its
// output register; the checksum builds up in a single 8-bit end-around-carry adder.
// in_stall stays high until the last byte has entered the output register.
// The address register takes a write in any cycle (cfg_ready is always high).
module sport_sensor_poll_responder
  import ssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] value_id,
  input  logic [31:0] value_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  tx_byte,
  output logic        last_byte
);

  logic [7:0]  sensor_address;
  logic [7:0]  previous_byte;
  logic        reply_pending;
  logic [15:0] stored_id;
  logic [31:0] stored_value;

  frame_req_t  req;
  frame_stat_t stat;
  logic        in_take;
  logic        poll_hit;

  assign cfg_ready = 1'b1;
  assign in_stall  = stat.busy;
  assign in_take   = in_valid && !in_stall;
  assign poll_hit  = in_take && !action && (previous_byte == FRAME_START)
                     && (rx_byte == sensor_address) && reply_pending;

  assign req.start      = poll_hit;
  assign req.value_id   = stored_id;
  assign req.value_word = stored_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_address <= '0;
      previous_byte  <= '0;
      reply_pending  <= 1'b0;
      stored_id      <= '0;
      stored_value   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sensor_address <= cfg_data;
      end
      if (in_take) begin
        if (action) begin
          stored_id     <= value_id;
          stored_value  <= value_word;
          reply_pending <= 1'b1;
        end else begin
          previous_byte <= rx_byte;
          if (poll_hit) begin
            reply_pending <= 1'b0;
          end
        end
      end
    end
  end

  ssp_frame_tx u_frame_tx (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_byte   (tx_byte),
    .last_byte (last_byte)
  );

  // a poll reply consumes the pending value
  a_poll_clears: assert property (@(posedge clk) disable iff (rst)
    poll_hit |=> (!reply_pending && stat.busy))
    else $error("poll reply did not clear pending flag");

  // an escape mark is never the end of a frame
  a_escape_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (tx_byte == ESCAPE_MARK)) |-> !last_byte)
    else $error("escape mark flagged as last byte");

  // no new frame can start while one is still being serialized
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !poll_hit)
    else $error("poll accepted during frame");

endmodule

/* design/ssp_frame_tx.sv */
// reply frame serializer: byte sequencer, shared checksum adder, byte stuffing
// and the output register; depends on ssp_pkg
module ssp_frame_tx
  import ssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  frame_req_t  req,
  output frame_stat_t stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  tx_byte,
  output logic        last_byte
);

  tx_state_t   state, state_next;
  logic [2:0]  idx, idx_next;
  logic        esc, esc_next;
  logic [7:0]  sum, sum_next;
  logic [15:0] id_reg;
  logic [31:0] word_reg;
  logic        out_valid_next;
  logic [7:0]  tx_byte_next;
  logic        last_byte_next;

  logic        out_free;
  logic [7:0]  cur;
  logic [8:0]  add_wide;
  logic [7:0]  add_eac;
  logic        needs_stuff;

  assign out_free = !out_valid || !out_stall;
  assign stat.busy = (state == ST_SEND);

  always_comb begin
    unique case (idx)
      3'd0: cur = DATA_HEADER;
      3'd1: cur = id_reg[7:0];
      3'd2: cur = id_reg[15:8];
      3'd3: cur = word_reg[7:0];
      3'd4: cur = word_reg[15:8];
      3'd5: cur = word_reg[23:16];
      3'd6: cur = word_reg[31:24];
      default: cur = ~sum;
    endcase
  end

  // end-around carry adder, shared over all header and data bytes
  assign add_wide = {1'b0, sum} + {1'b0, cur};
  assign add_eac  = add_wide[7:0] + {7'd0, add_wide[8]};

  assign needs_stuff = (idx != 3'd0) && ((cur == FRAME_START) || (cur == ESCAPE_MARK));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      esc       <= 1'b0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      esc       <= esc_next;
      sum       <= sum_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    tx_byte   <= tx_byte_next;
    last_byte <= last_byte_next;
    if (req.start) begin
      id_reg   <= req.value_id;
      word_reg <= req.value_word;
    end
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    esc_next       = esc;
    sum_next       = sum;
    out_valid_next = out_valid && out_stall;
    tx_byte_next   = tx_byte;
    last_byte_next = last_byte;
    unique case (state)
      ST_IDLE: begin
        if (req.start) begin
          state_next = ST_SEND;
          idx_next   = '0;
          esc_next   = 1'b0;
          sum_next   = '0;
        end
      end
      ST_SEND: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          if (esc) begin
            tx_byte_next   = cur ^ ESCAPE_FLIP;
            last_byte_next = (idx == LAST_INDEX);
            esc_next       = 1'b0;
          end else if (needs_stuff) begin
            tx_byte_next   = ESCAPE_MARK;
            last_byte_next = 1'b0;
            esc_next       = 1'b1;
          end else begin
            tx_byte_next   = cur;
            last_byte_next = (idx == LAST_INDEX);
          end
          if (esc || !needs_stuff) begin
            if (idx == LAST_INDEX) begin
              state_next = ST_IDLE;
            end else begin
              sum_next = add_eac;
              idx_next = idx + 3'd1;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* verif/sport_sensor_poll_responder_tb.sv */
// testbench for sport_sensor_poll_responder: directed table then random load and poll traffic,
// every transmitted byte checked against an in-bench frame builder
// depends on ssp_pkg and the responder rtl
`timescale 1ns / 100ps

module sport_sensor_poll_responder_tb
  import ssp_pkg::*;
();

  localparam logic ACT_RX   = 1'b0;
  localparam logic ACT_LOAD = 1'b1;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_beat_t;

  typedef struct packed {
    logic        act;
    logic [7:0]  rx;
    logic [15:0] id;
    logic [31:0] word;
    logic        typed;
    logic [4:0]  n_bytes;
    logic [7:0]  fin;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        action;
  logic [7:0]  rx_byte;
  logic [15:0] value_id;
  logic [31:0] value_word;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  tx_byte;
  logic        last_byte;

  logic        row_typed;
  logic [4:0]  row_len;
  logic [7:0]  row_final;
  logic        hold_req;

  logic [7:0]  addr_copy = 8'h00;
  logic [7:0]  prev_rx   = 8'h00;
  logic        reply_due = 1'b0;
  logic [15:0] held_id   = 16'h0000;
  logic [31:0] held_word = 32'h0;
  tx_beat_t    tx_expect[$];
  plan_row_t   plan[$];

  logic [7:0]  poll_addr;
  int          mismatch_count = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left;
  bit          held;
  int          cycle_count;

  sport_sensor_poll_responder u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .rx_byte    (rx_byte),
    .value_id   (value_id),
    .value_word (value_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tx_byte    (tx_byte),
    .last_byte  (last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit bump_fail();
    mismatch_count++;
    return mismatch_count <= MAX_REPORTS;
  endfunction

  task automatic predict_reply(input logic act, input logic [7:0] rx, input logic [15:0] id,
                               input logic [31:0] word, output int n, output logic [7:0] fin);
    logic [7:0] frame [0:7];
    logic [8:0] sum;
    n = 0;
    fin = 8'h00;
    if (act == ACT_LOAD) begin
      held_id = id;
      held_word = word;
      reply_due = 1'b1;
    end else begin
      if (prev_rx == FRAME_START && rx == addr_copy && reply_due) begin
        frame[0] = DATA_HEADER;
        frame[1] = held_id[7:0];
        frame[2] = held_id[15:8];
        frame[3] = held_word[7:0];
        frame[4] = held_word[15:8];
        frame[5] = held_word[23:16];
        frame[6] = held_word[31:24];
        sum = {1'b0, frame[0]};
        for (int i = 1; i < 7; i++) begin
          sum = sum + frame[i];
          sum = {1'b0, sum[7:0]} + sum[8];
        end
        frame[7] = 8'hFF - sum[7:0];
        for (int i = 0; i < 8; i++) begin
          if (i > 0 && (frame[i] == FRAME_START || frame[i] == ESCAPE_MARK)) begin
            tx_expect.push_back({ESCAPE_MARK, 1'b0});
            tx_expect.push_back({frame[i] ^ ESCAPE_FLIP, i == 7});
            n += 2;
          end else begin
            tx_expect.push_back({frame[i], i == 7});
            n += 1;
          end
        end
        fin = tx_expect[$].data;
        reply_due = 1'b0;
      end
      prev_rx = rx;
    end
  endtask

  always @(posedge clk) begin : score
    int n;
    logic [7:0] fin;
    tx_beat_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) addr_copy = cfg_data;
      if (in_valid && !in_stall) begin
        predict_reply(action, rx_byte, value_id, value_word, n, fin);
        if (row_typed && (n != row_len || (n != 0 && fin != row_final))) begin
          if (bump_fail())
            $display("table row: expected %0d bytes ending %h, frame builder gave %0d ending %h",
                     row_len, row_final, n, fin);
        end
      end
      if (out_valid && !out_stall) begin
        if (tx_expect.size() == 0) begin
          if (bump_fail())
            $display("unexpected byte: tx_byte %h last_byte %b", tx_byte, last_byte);
        end else begin
          want = tx_expect.pop_front();
          if (want.data !== tx_byte || want.last !== last_byte) begin
            if (bump_fail())
              $display("byte mismatch: expected %h/%b, got %h/%b",
                       want.data, want.last, tx_byte, last_byte);
          end
        end
      end
    end
  end

  // receiver side, with one long hold-off when requested
  initial begin
    out_stall <= 1'b0;
    held = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return FRAME_START;
      1: return ESCAPE_MARK;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_row(input logic act, input logic [7:0] rx, input logic [15:0] id,
                         input logic [31:0] word, input logic typed, input logic [4:0] n_bytes,
                         input logic [7:0] fin);
    plan.push_back({act, rx, id, word, typed, n_bytes, fin});
  endtask

  task automatic send_item(input logic act, input logic [7:0] rx, input logic [15:0] id,
                           input logic [31:0] word, input logic typed = 1'b0,
                           input logic [4:0] n_bytes = 5'd0, input logic [7:0] fin = 8'h00);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    rx_byte    <= rx;
    value_id   <= id;
    value_word <= word;
    row_typed  <= typed;
    row_len    <= n_bytes;
    row_final  <= fin;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tx_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] a);
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    poll_addr = a;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input int s_pct, input int r_pct);
    int sent;
    int pick;
    logic [7:0] rx;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_item(ACT_LOAD, 8'($urandom_range(0, 255)), {pick_byte(), pick_byte()},
                  {pick_byte(), pick_byte(), pick_byte(), pick_byte()});
        sent += 1;
      end else if (pick < 60) begin
        send_item(ACT_RX, FRAME_START, 16'($urandom), $urandom);
        send_item(ACT_RX, poll_addr, 16'($urandom), $urandom);
        sent += 2;
      end else begin
        if (pick < 70) rx = FRAME_START;
        else if (pick < 80) rx = poll_addr;
        else rx = 8'($urandom_range(0, 255));
        send_item(ACT_RX, rx, 16'($urandom), $urandom);
        sent += 1;
      end
    end
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_data   <= 8'h00;
    in_valid   <= 1'b0;
    action     <= ACT_RX;
    rx_byte    <= 8'h00;
    value_id   <= 16'h0000;
    value_word <= 32'h0;
    row_typed  <= 1'b0;
    row_len    <= 5'd0;
    row_final  <= 8'h00;
    hold_req   <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    poll_addr = 8'h00;

    // poll with nothing pending
    add_row(ACT_RX,   FRAME_START, 16'h0000, 32'h00000000, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   8'h00,       16'h0000, 32'h00000000, 1'b1, 5'd0, 8'h00);
    // all-zero value
    add_row(ACT_LOAD, 8'h00,       16'h0000, 32'h00000000, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   FRAME_START, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   8'h00,       16'hFFFF, 32'hFFFFFFFF, 1'b1, 5'd8, 8'hEF);
    // load while pending replaces the value
    add_row(ACT_LOAD, 8'hFF,       16'hFFFF, 32'hFFFFFFFF, 1'b1, 5'd0, 8'h00);
    add_row(ACT_LOAD, 8'h00,       16'h1234, 32'h5678ABCD, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   FRAME_START, 16'h0000, 32'h00000000, 1'b0, 5'd0, 8'h00);
    add_row(ACT_RX,   8'h00,       16'h0000, 32'h00000000, 1'b0, 5'd0, 8'h00);
    // checksum needs stuffing
    add_row(ACT_LOAD, 8'h00,       16'h0071, 32'h00000000, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   FRAME_START, 16'h0000, 32'h00000000, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   8'h00,       16'h0000, 32'h00000000, 1'b1, 5'd9, 8'h5E);
    add_row(ACT_LOAD, 8'h00,       16'h0072, 32'h00000000, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   FRAME_START, 16'h0000, 32'h00000000, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   8'h00,       16'h0000, 32'h00000000, 1'b1, 5'd9, 8'h5D);
    // stuffed data bytes, and a poll broken by another byte
    add_row(ACT_LOAD, 8'h00,       16'h7E7D, 32'h7D7E7D7E, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   FRAME_START, 16'h0000, 32'h00000000, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   8'h01,       16'h0000, 32'h00000000, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   8'h00,       16'h0000, 32'h00000000, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   FRAME_START, 16'h0000, 32'h00000000, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   FRAME_START, 16'h0000, 32'h00000000, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   8'h00,       16'h0000, 32'h00000000, 1'b0, 5'd0, 8'h00);
    // all-ones value
    add_row(ACT_LOAD, 8'h00,       16'hFFFF, 32'hFFFFFFFF, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   FRAME_START, 16'h0000, 32'h00000000, 1'b1, 5'd0, 8'h00);
    add_row(ACT_RX,   8'h00,       16'h0000, 32'h00000000, 1'b1, 5'd8, 8'hEF);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_address(8'h00);
    for (int i = 0; i < plan.size(); i++)
      send_item(plan[i].act, plan[i].rx, plan[i].id, plan[i].word,
                plan[i].typed, plan[i].n_bytes, plan[i].fin);
    settle();

    write_address(8'hFF);
    run_random(65, 26, 64);
    settle();

    write_address(FRAME_START);
    run_random(64, 64, 26);
    // long receiver hold-off while items keep coming
    send_idle_pct = 0;
    hold_req <= 1'b1;
    repeat (4) begin
      send_item(ACT_LOAD, 8'($urandom_range(0, 255)), 16'($urandom), $urandom);
      send_item(ACT_RX, FRAME_START, 16'($urandom), $urandom);
      send_item(ACT_RX, poll_addr, 16'($urandom), $urandom);
    end
    settle();

    write_address(8'($urandom_range(0, 255)));
    run_random(55, 0, 0);
    settle();

    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
design/ssp_pkg.sv
design/ssp_frame_tx.sv
design/sport_sensor_poll_responder.sv
verif/sport_sensor_poll_responder_tb.sv
